/* src/art_pkg.sv */
// Shared types and codes of the acknowledgement retransmit tracker.
// No dependencies.
`default_nettype none
package art_pkg;
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_TRACK = 2'd1;
	localparam logic [1:0] ACT_ACK   = 2'd2;
	localparam logic [1:0] ACT_TICK  = 2'd3;

	localparam logic [3:0] KIND_IDLE    = 4'd0;
	localparam logic [3:0] KIND_TRACKED = 4'd1;
	localparam logic [3:0] KIND_FULL    = 4'd2;
	localparam logic [3:0] KIND_NOTRK   = 4'd3;
	localparam logic [3:0] KIND_ACKED   = 4'd4;
	localparam logic [3:0] KIND_NAK     = 4'd5;
	localparam logic [3:0] KIND_RETX    = 4'd6;
	localparam logic [3:0] KIND_TIMEOUT = 4'd7;
	localparam logic [3:0] KIND_NOMATCH = 4'd8;
	localparam logic [3:0] KIND_CLEARED = 4'd9;

	localparam logic [2:0] REG_OWN_ID   = 3'd0;
	localparam logic [2:0] REG_BCAST    = 3'd1;
	localparam logic [2:0] REG_RT_PORT  = 3'd2;
	localparam logic [2:0] REG_INTERVAL = 3'd3;
	localparam logic [2:0] REG_JITTER   = 3'd4;
	localparam logic [2:0] REG_RETX     = 3'd5;

	localparam int DIV_STEPS = 32;
	localparam logic [47:0] DUE_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] own_node_id;
		logic [31:0] broadcast_address;
		logic [8:0]  routing_port;
		logic [19:0] retry_interval_ms;
		logic [15:0] jitter_max_ms;
		logic [7:0]  retransmissions;
	} art_cfg_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic due_calc;
		logic exec;
		logic tick_step;
		logic sum_step;
		logic emit;
	} art_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic emit_last;
	} art_sts_t;
endpackage
`default_nettype wire

/* src/art_ctrl.sv */
// Sequencer of the retransmit tracker: divide, due time, execute or tick scan, summary scan, emit.
// Depends on art_pkg.
`default_nettype none
module art_ctrl import art_pkg::*; #(
	parameter int PENDING_SLOTS = 8,
	parameter int IW = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire art_sts_t      sts,
	output art_cmd_t           cmd,
	output logic [IW-1:0]      idx
);
	typedef enum logic [2:0] {S_IDLE, S_DIV, S_DUE, S_EXEC, S_TICK, S_SUM, S_EMIT} state_t;
	state_t state_q;
	logic [6:0] cnt_q;
	localparam logic [6:0] DIV_LAST  = 7'(DIV_STEPS - 1);
	localparam logic [6:0] SCAN_LAST = 7'(PENDING_SLOTS - 1);

	assign busy = (state_q != S_IDLE);
	assign idx  = cnt_q[IW-1:0];

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = start;
			S_DIV:  cmd.div_step = 1'b1;
			S_DUE:  cmd.due_calc = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			S_TICK: cmd.tick_step = 1'b1;
			S_SUM:  cmd.sum_step = 1'b1;
			S_EMIT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DUE;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 7'd1;
				end
				S_DUE: state_q <= sts.is_tick ? S_TICK : S_EXEC;
				S_EXEC: state_q <= S_SUM;
				S_TICK, S_SUM: begin
					if (cnt_q == SCAN_LAST) begin
						state_q <= (state_q == S_TICK) ? S_SUM : S_EMIT;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 7'd1;
				end
				S_EMIT: if (sts.emit_last) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/art_dpath.sv */
// Slot table, jitter remainder unit, summary scan and result registers.
// Depends on art_pkg; driven by art_ctrl commands.
`default_nettype none
module art_dpath import art_pkg::*; #(
	parameter int PENDING_SLOTS = 8,
	parameter int MAX_FRAME = 256,
	parameter int IW = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire art_cfg_t    cfg,
	input  wire art_cmd_t    cmd,
	input  wire logic [IW-1:0] idx,
	output art_sts_t         sts,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] packet_id,
	input  wire logic [31:0] dest_addr,
	input  wire logic [8:0]  port_number,
	input  wire logic        ack_requested,
	input  wire logic [8:0]  frame_length,
	input  wire logic [31:0] ack_ref_id,
	input  wire logic        is_nak,
	input  wire logic [47:0] now_ms,
	input  wire logic [31:0] random_value,
	output logic             strobe,
	output logic [3:0]       kind,
	output logic [31:0]      entry_id,
	output logic [31:0]      entry_dest,
	output logic [8:0]       entry_port,
	output logic [2:0]       slot_index,
	output logic [7:0]       attempts_remaining,
	output logic [3:0]       pending_count,
	output logic [47:0]      next_due_ms,
	output logic             next_due_valid,
	output logic             last
);
	localparam int N = PENDING_SLOTS;
	localparam int FW = 13;

	// latched item
	logic [1:0]  act_q;
	logic [31:0] pid_q, dst_q, req_q;
	logic [8:0]  prt_q, flen_q;
	logic        want_q, nak_q;
	logic [47:0] now_q;
	logic [31:0] dvd_q;
	logic [16:0] rem_q;
	logic [47:0] due_q;

	// slot table
	logic [N-1:0]  valid_q, flag_q, to_q;
	logic [31:0]   sid_q  [N];
	logic [31:0]   sdst_q [N];
	logic [8:0]    sprt_q [N];
	logic [47:0]   sdue_q [N];
	logic [7:0]    satt_q [N];

	// single result of non-tick actions
	logic [3:0]  rk_q;
	logic [31:0] rid_q, rdst_q;
	logic [8:0]  rprt_q;
	logic [IW-1:0] rslot_q;
	logic [7:0]  ratt_q;

	// summary
	logic [6:0]  cnt_q;
	logic [47:0] min_q;
	logic        any_q;

	// output registers
	logic        strobe_q, last_q, ndv_q;
	logic [3:0]  kind_q, pc_q;
	logic [31:0] eid_q, edst_q;
	logic [8:0]  eprt_q;
	logic [2:0]  eslot_q;
	logic [7:0]  eatt_q;
	logic [47:0] nd_q;

	// divider step
	logic [16:0] divisor;
	logic [17:0] trial;
	assign divisor = {1'b0, cfg.jitter_max_ms} + 17'd1;
	assign trial   = {rem_q, dvd_q[31]};

	// due time, saturating
	logic [48:0] due_sum;
	assign due_sum = {1'b0, now_q} + 49'({1'b0, cfg.retry_interval_ms} + 21'(rem_q));

	// free slot, ack match and flagged slot search
	logic          free_found, hit_found, ack_ok, reject;
	logic [IW-1:0] free_idx, hit_idx, pick_idx;
	logic          pick_found;
	logic [N-1:0]  rest;
	always_comb begin
		free_found = 1'b0; free_idx = '0;
		hit_found = 1'b0;  hit_idx = '0;
		pick_found = 1'b0; pick_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1; free_idx = IW'(i);
			end
			if (valid_q[i] && sid_q[i] == req_q) begin
				hit_found = 1'b1; hit_idx = IW'(i);
			end
			if (flag_q[i]) begin
				pick_found = 1'b1; pick_idx = IW'(i);
			end
		end
		rest = flag_q;
		rest[pick_idx] = 1'b0;
	end
	assign ack_ok = (prt_q == cfg.routing_port) && (dst_q == cfg.own_node_id)
		&& (req_q != 32'd0) && hit_found;
	assign reject = !want_q || pid_q == 32'd0 || dst_q == cfg.broadcast_address
		|| dst_q == cfg.own_node_id || prt_q == cfg.routing_port || flen_q == 9'd0
		|| FW'(flen_q) > FW'(MAX_FRAME);

	assign sts.is_tick   = (act_q == ACT_TICK);
	assign sts.emit_last = (act_q != ACT_TICK) || (rest == '0);

	// control state of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			flag_q   <= '0;
			to_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				flag_q <= '0;
				to_q   <= '0;
			end
			if (cmd.exec) begin
				case (act_q)
					ACT_CLEAR: valid_q <= '0;
					ACT_TRACK: if (!reject && free_found) valid_q[free_idx] <= 1'b1;
					ACT_ACK:   if (ack_ok) valid_q[hit_idx] <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.tick_step && valid_q[idx] && sdue_q[idx] <= now_q) begin
				flag_q[idx] <= 1'b1;
				if (satt_q[idx] == 8'd0) begin
					to_q[idx]    <= 1'b1;
					valid_q[idx] <= 1'b0;
				end
			end
			if (cmd.emit && pick_found) flag_q[pick_idx] <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action; pid_q <= packet_id; dst_q <= dest_addr;
			prt_q <= port_number; want_q <= ack_requested; flen_q <= frame_length;
			req_q <= ack_ref_id; nak_q <= is_nak; now_q <= now_ms;
			dvd_q <= random_value; rem_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= (trial >= {1'b0, divisor}) ? 17'(trial - {1'b0, divisor}) : trial[16:0];
		end
		if (cmd.due_calc) due_q <= due_sum[48] ? DUE_MAX : due_sum[47:0];
		if (cmd.exec) begin
			case (act_q)
				ACT_CLEAR: begin
					rk_q <= KIND_CLEARED; rid_q <= '0; rdst_q <= '0; rprt_q <= '0;
					rslot_q <= '0; ratt_q <= '0;
				end
				ACT_TRACK: begin
					rid_q <= pid_q; rdst_q <= dst_q; rprt_q <= prt_q;
					if (reject || !free_found) begin
						rk_q <= reject ? KIND_NOTRK : KIND_FULL;
						rslot_q <= '0; ratt_q <= '0;
					end else begin
						rk_q <= KIND_TRACKED;
						rslot_q <= free_idx;
						ratt_q <= cfg.retransmissions;
						sid_q[free_idx]  <= pid_q;
						sdst_q[free_idx] <= dst_q;
						sprt_q[free_idx] <= prt_q;
						satt_q[free_idx] <= cfg.retransmissions;
						sdue_q[free_idx] <= due_q;
					end
				end
				ACT_ACK: begin
					rid_q <= req_q;
					if (ack_ok) begin
						rk_q <= nak_q ? KIND_NAK : KIND_ACKED;
						rdst_q <= sdst_q[hit_idx]; rprt_q <= sprt_q[hit_idx];
						rslot_q <= hit_idx; ratt_q <= satt_q[hit_idx];
					end else begin
						rk_q <= KIND_NOMATCH; rdst_q <= '0; rprt_q <= '0;
						rslot_q <= '0; ratt_q <= '0;
					end
				end
				default: begin
					rk_q <= KIND_IDLE; rid_q <= '0; rdst_q <= '0; rprt_q <= '0;
					rslot_q <= '0; ratt_q <= '0;
				end
			endcase
		end
		if (cmd.tick_step && valid_q[idx] && sdue_q[idx] <= now_q
			&& satt_q[idx] != 8'd0) begin
			satt_q[idx] <= satt_q[idx] - 8'd1;
			sdue_q[idx] <= due_q;
		end
		if (cmd.sum_step) begin
			if (idx == '0) begin
				cnt_q <= valid_q[idx] ? 7'd1 : 7'd0;
				min_q <= valid_q[idx] ? sdue_q[idx] : 48'd0;
				any_q <= valid_q[idx];
			end else if (valid_q[idx]) begin
				cnt_q <= cnt_q + 7'd1;
				any_q <= 1'b1;
				if (!any_q || sdue_q[idx] < min_q) min_q <= sdue_q[idx];
			end
		end
		if (cmd.emit) begin
			pc_q  <= cnt_q[3:0];
			nd_q  <= min_q;
			ndv_q <= any_q;
			last_q <= sts.emit_last;
			if (act_q != ACT_TICK) begin
				kind_q <= rk_q; eid_q <= rid_q; edst_q <= rdst_q; eprt_q <= rprt_q;
				eslot_q <= 3'(rslot_q); eatt_q <= ratt_q;
			end else if (pick_found) begin
				kind_q <= to_q[pick_idx] ? KIND_TIMEOUT : KIND_RETX;
				eid_q <= sid_q[pick_idx]; edst_q <= sdst_q[pick_idx];
				eprt_q <= sprt_q[pick_idx]; eslot_q <= 3'(pick_idx);
				eatt_q <= to_q[pick_idx] ? 8'd0 : satt_q[pick_idx];
			end else begin
				kind_q <= KIND_IDLE; eid_q <= '0; edst_q <= '0; eprt_q <= '0;
				eslot_q <= '0; eatt_q <= '0;
			end
		end
	end

	assign strobe = strobe_q;
	assign kind = kind_q;
	assign entry_id = eid_q;
	assign entry_dest = edst_q;
	assign entry_port = eprt_q;
	assign slot_index = eslot_q;
	assign attempts_remaining = eatt_q;
	assign pending_count = pc_q;
	assign next_due_ms = nd_q;
	assign next_due_valid = ndv_q;
	assign last = last_q;
endmodule
`default_nettype wire

/* src/ack_retransmit_tracker.sv */
// Top level of the acknowledgement retransmit tracker: config registers,
// sequencer and datapath. Depends on art_pkg, art_ctrl, art_dpath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  item in  | start & !busy      | action .. random_value
//  result   | strobe (1 cycle)   | kind .. last
//  config   | psel&penable&pwrite| paddr (reg index * 4), pwdata
//
// Every item runs a 32-step remainder of random_value by (jitter_max_ms+1),
// a due-time step, then an execute step (clear/track/ack) or a tick scan
// of all slots, then a summary scan of all slots and one emit step per
// result. busy stays high until the last result is emitted. Each result
// shows on the ports the cycle after its emit cycle. Results appear one
// per cycle and cannot be stalled. Reset empties the table and loads the
// register defaults.
`default_nettype none
module ack_retransmit_tracker import art_pkg::*; #(
	parameter int PENDING_SLOTS = 8,
	parameter int MAX_FRAME = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] packet_id,
	input  wire logic [31:0] dest_addr,
	input  wire logic [8:0]  port_number,
	input  wire logic        ack_requested,
	input  wire logic [8:0]  frame_length,
	input  wire logic [31:0] ack_ref_id,
	input  wire logic        is_nak,
	input  wire logic [47:0] now_ms,
	input  wire logic [31:0] random_value,
	output logic             strobe,
	output logic [3:0]       kind,
	output logic [31:0]      entry_id,
	output logic [31:0]      entry_dest,
	output logic [8:0]       entry_port,
	output logic [2:0]       slot_index,
	output logic [7:0]       attempts_remaining,
	output logic [3:0]       pending_count,
	output logic [47:0]      next_due_ms,
	output logic             next_due_valid,
	output logic             last
);
	localparam int IW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

	art_cfg_t cfg_q;
	art_cmd_t cmd;
	art_sts_t sts;
	logic [IW-1:0] idx;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// register file, written in the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_node_id       <= 32'd0;
			cfg_q.broadcast_address <= 32'hFFFF_FFFF;
			cfg_q.routing_port      <= 9'd5;
			cfg_q.retry_interval_ms <= 20'd5000;
			cfg_q.jitter_max_ms     <= 16'd0;
			cfg_q.retransmissions   <= 8'd3;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_OWN_ID:   cfg_q.own_node_id       <= pwdata;
				REG_BCAST:    cfg_q.broadcast_address <= pwdata;
				REG_RT_PORT:  cfg_q.routing_port      <= pwdata[8:0];
				REG_INTERVAL: cfg_q.retry_interval_ms <= pwdata[19:0];
				REG_JITTER:   cfg_q.jitter_max_ms     <= pwdata[15:0];
				REG_RETX:     cfg_q.retransmissions   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OWN_ID:   prdata = cfg_q.own_node_id;
			REG_BCAST:    prdata = cfg_q.broadcast_address;
			REG_RT_PORT:  prdata = 32'(cfg_q.routing_port);
			REG_INTERVAL: prdata = 32'(cfg_q.retry_interval_ms);
			REG_JITTER:   prdata = 32'(cfg_q.jitter_max_ms);
			REG_RETX:     prdata = 32'(cfg_q.retransmissions);
			default:      prdata = 32'd0;
		endcase
	end

	art_ctrl #(.PENDING_SLOTS(PENDING_SLOTS), .IW(IW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .cmd(cmd), .idx(idx)
	);

	art_dpath #(.PENDING_SLOTS(PENDING_SLOTS), .MAX_FRAME(MAX_FRAME), .IW(IW)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd), .idx(idx), .sts(sts),
		.action(action), .packet_id(packet_id), .dest_addr(dest_addr),
		.port_number(port_number), .ack_requested(ack_requested),
		.frame_length(frame_length),
		.ack_ref_id(ack_ref_id), .is_nak(is_nak), .now_ms(now_ms),
		.random_value(random_value), .strobe(strobe), .kind(kind),
		.entry_id(entry_id), .entry_dest(entry_dest), .entry_port(entry_port),
		.slot_index(slot_index), .attempts_remaining(attempts_remaining),
		.pending_count(pending_count), .next_due_ms(next_due_ms),
		.next_due_valid(next_due_valid), .last(last)
	);
endmodule
`default_nettype wire
